// ===== hw/rtl/keyframe_vector_interpolator_macros.svh =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

`define KVI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define KVI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define KVI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KVI_ASSERT(lbl, clk, rstn, prop, msg)

`define KVI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`define KVI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/kvi_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator package
// Field widths, status codes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int STAT_W       = 3;
  localparam int FRAC_W       = 24;
  localparam int PROD_W       = VAL_W + FRAC_W + 2;
  localparam int DEF_MAX_KEYS = 64;

  typedef enum logic [STAT_W-1:0] {
    ST_INTERP    = 3'd0,
    ST_SINGLE    = 3'd1,
    ST_NO_KEYS   = 3'd2,
    ST_CLAMPED   = 3'd3,
    ST_BAD_ORDER = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_KEY_RD,
    S_KEY_TAKE,
    S_SEG_RD,
    S_SEG_START,
    S_SEG_END,
    S_DIV,
    S_MUL,
    S_ACC,
    S_EMIT
  } kvi_state_e;

  typedef logic [2:0][VAL_W-1:0] vec3_t;

  typedef struct packed {
    logic [KEY_W-1:0] ktime;
    vec3_t            val;
  } key_t;

endpackage

// ===== hw/rtl/kvi_in_if.sv =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator input channel
// Valid/ready channel carrying one load or query transaction.
// ----------------------------------------------------------------------------
interface kvi_in_if;
  import kvi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [IDX_W-1:0]        key_index;
  logic [KEY_W-1:0]        key_time;
  logic signed [VAL_W-1:0] key_x;
  logic signed [VAL_W-1:0] key_y;
  logic signed [VAL_W-1:0] key_z;
  logic [KEY_W-1:0]        query_time;

  modport source (
    output valid, mode, key_index, key_time, key_x, key_y, key_z, query_time,
    input  ready
  );

  modport sink (
    input  valid, mode, key_index, key_time, key_x, key_y, key_z, query_time,
    output ready
  );

endinterface

// ===== hw/rtl/kvi_out_if.sv =====
// ----------------------------------------------------------------------------
// Keyframe vector interpolator output channel
// Valid/ready channel carrying one sampled vector and its status.
// ----------------------------------------------------------------------------
interface kvi_out_if;
  import kvi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] out_x;
  logic signed [VAL_W-1:0] out_y;
  logic signed [VAL_W-1:0] out_z;
  logic [STAT_W-1:0]       status;

  modport source (
    output valid, out_x, out_y, out_z, status,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, status,
    output ready
  );

endinterface

// ===== hw/rtl/keyframe_vector_interpolator.sv =====
// A load transaction (mode 0) writes one keyframe and gives no result; a
// query (mode 1) runs a one-key-per-cycle scan of the key memory followed by
// a restoring divider for the 24-bit fraction and a shared 33x25 multiplier
// used once per component. Clamped and bad-order queries end after the scan
// with one key read; single-key queries skip the scan. The input is not ready
// while a query is being worked on. A finished result sits in an output
// register, so a new transaction can be taken while it waits. key_count above
// MAX_KEYS is treated as MAX_KEYS.
// ----------------------------------------------------------------------------
// Keyframe vector interpolator
// Keyframe table with linear interpolation of an (x, y, z) value over time.
// ----------------------------------------------------------------------------
`include "keyframe_vector_interpolator_macros.svh"

module keyframe_vector_interpolator #(
  parameter int MAX_KEYS = kvi_pkg::DEF_MAX_KEYS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [kvi_pkg::CNT_W-1:0] cfg_wdata_i,
  kvi_in_if.sink                  in_i,
  kvi_out_if.source               out_o
);
  import kvi_pkg::*;

  localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int DCW = $clog2(FRAC_W);

  key_t mem [MAX_KEYS];
  key_t rd_data_q;

  kvi_state_e state_q, state_d;
  logic [CNT_W-1:0] key_count_q;

  logic          in_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  key_t          mem_wdata;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0]     n_q, n_d, idx_q, idx_d, n_sat;
  logic [KEY_W-1:0]  t_q, t_d, first_q, first_d, prev_q, prev_d;
  logic              found_q, found_d;
  logic [AW-1:0]     seg_q, seg_d, addr_q, addr_d;
  status_e           stat_q, stat_d;
  vec3_t             res_q, res_d, start_q, start_d, end_q, end_d;
  logic [KEY_W-1:0]  st_time_q, st_time_d;
  logic [KEY_W-1:0]  rem_q, rem_d, den_q, den_d;
  logic [FRAC_W-1:0] quo_q, quo_d;
  logic [DCW-1:0]    div_cnt_q, div_cnt_d;
  logic [1:0]        comp_q, comp_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic                    out_valid_q, out_valid_d;
  vec3_t                   out_q, out_d;
  status_e                 out_stat_q, out_stat_d;

  logic [KEY_W:0]           div_sh;
  logic                     div_ge;
  logic signed [VAL_W:0]    diff;
  logic signed [FRAC_W:0]   fac;
  logic signed [PROD_W-1:0] rnd;
  logic                     out_free;

  assign n_sat    = (int'(key_count_q) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign div_sh = {rem_q, 1'b0};
  assign div_ge = div_sh >= {1'b0, den_q};
  assign diff   = $signed({end_q[comp_q][VAL_W-1], end_q[comp_q]})
                - $signed({start_q[comp_q][VAL_W-1], start_q[comp_q]});
  assign fac    = $signed({1'b0, quo_q});
  assign rnd    = prod_q + (PROD_W'(1) << (FRAC_W - 1));

  // key memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.mode) begin
          if (n_sat == '0) begin
            state_d = S_EMIT;
          end else if (n_sat == CW'(1)) begin
            state_d = S_KEY_RD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q > CW'(1) && rd_data_q.ktime <= prev_q) begin
          state_d = S_KEY_RD;
        end else if (idx_q == n_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (t_q < first_q || t_q >= prev_q) begin
          state_d = S_KEY_RD;
        end else begin
          state_d = S_SEG_RD;
        end
      end
      S_KEY_RD:    state_d = S_KEY_TAKE;
      S_KEY_TAKE:  state_d = S_EMIT;
      S_SEG_RD:    state_d = S_SEG_START;
      S_SEG_START: state_d = S_SEG_END;
      S_SEG_END:   state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DCW'(FRAC_W - 1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL:       state_d = S_ACC;
      S_ACC: begin
        if (comp_q == 2'd2) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs to channel and memory
  always_comb begin
    in_ready  = (state_q == S_IDLE);
    mem_we    = in_ready && in_i.valid && !in_i.mode && (int'(in_i.key_index) < MAX_KEYS);
    mem_waddr = AW'(in_i.key_index);
    mem_wdata = '{ktime: in_i.key_time, val: {in_i.key_z, in_i.key_y, in_i.key_x}};
    case (state_q)
      S_SCAN:      rd_addr = AW'(idx_q);
      S_SEG_RD:    rd_addr = seg_q;
      S_SEG_START: rd_addr = seg_q + AW'(1);
      default:     rd_addr = addr_q;
    endcase
  end

  // datapath
  always_comb begin
    n_d         = n_q;
    idx_d       = idx_q;
    t_d         = t_q;
    first_d     = first_q;
    prev_d      = prev_q;
    found_d     = found_q;
    seg_d       = seg_q;
    addr_d      = addr_q;
    stat_d      = stat_q;
    res_d       = res_q;
    start_d     = start_q;
    end_d       = end_q;
    st_time_d   = st_time_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    comp_d      = comp_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    out_stat_d  = out_stat_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid && in_i.mode) begin
          n_d     = n_sat;
          t_d     = in_i.query_time;
          idx_d   = '0;
          found_d = 1'b0;
          addr_d  = '0;
          res_d   = '0;
          stat_d  = (n_sat == '0) ? ST_NO_KEYS : ST_SINGLE;
        end
      end
      S_SCAN: begin
        idx_d = idx_q + CW'(1);
        if (idx_q == CW'(1)) begin
          first_d = rd_data_q.ktime;
          prev_d  = rd_data_q.ktime;
        end else if (idx_q > CW'(1)) begin
          if (rd_data_q.ktime <= prev_q) begin
            addr_d = '0;
            stat_d = ST_BAD_ORDER;
          end else begin
            prev_d = rd_data_q.ktime;
            if (!found_q && t_q < rd_data_q.ktime) begin
              found_d = 1'b1;
              seg_d   = AW'(idx_q - CW'(2));
            end
          end
        end
      end
      S_DECIDE: begin
        // prev_q now holds the last key time
        if (t_q < first_q) begin
          addr_d = '0;
          stat_d = ST_CLAMPED;
        end else if (t_q > prev_q) begin
          addr_d = AW'(n_q - CW'(1));
          stat_d = ST_CLAMPED;
        end else begin
          addr_d = AW'(n_q - CW'(1));
          stat_d = ST_INTERP;
        end
      end
      S_KEY_TAKE: begin
        res_d = rd_data_q.val;
      end
      S_SEG_START: begin
        st_time_d = rd_data_q.ktime;
        start_d   = rd_data_q.val;
      end
      S_SEG_END: begin
        end_d     = rd_data_q.val;
        rem_d     = t_q - st_time_q;
        den_d     = rd_data_q.ktime - st_time_q;
        quo_d     = '0;
        div_cnt_d = '0;
        comp_d    = '0;
        stat_d    = ST_INTERP;
      end
      S_DIV: begin
        rem_d     = div_ge ? KEY_W'(div_sh - {1'b0, den_q}) : div_sh[KEY_W-1:0];
        quo_d     = {quo_q[FRAC_W-2:0], div_ge};
        div_cnt_d = div_cnt_q + DCW'(1);
      end
      S_MUL: begin
        prod_d = diff * fac;
      end
      S_ACC: begin
        res_d[comp_q] = start_q[comp_q] + rnd[FRAC_W +: VAL_W];
        comp_d        = comp_q + 2'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          out_stat_d  = stat_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_count_q <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      div_cnt_q   <= '0;
      comp_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      found_q     <= found_d;
      div_cnt_q   <= div_cnt_d;
      comp_q      <= comp_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    first_q    <= first_d;
    prev_q     <= prev_d;
    seg_q      <= seg_d;
    addr_q     <= addr_d;
    stat_q     <= stat_d;
    res_q      <= res_d;
    start_q    <= start_d;
    end_q      <= end_d;
    st_time_q  <= st_time_d;
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    prod_q     <= prod_d;
    out_q      <= out_d;
    out_stat_q <= out_stat_d;
  end

  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = out_q[0];
  assign out_o.out_y  = out_q[1];
  assign out_o.out_z  = out_q[2];
  assign out_o.status = out_stat_q;

  `KVI_ASSERT(a_rem_below_den, clk_i, rst_ni, (state_q == S_DIV) |-> (rem_q < den_q), "divider remainder not below divisor")
  `KVI_ASSERT_IMP(a_div_cnt, clk_i, rst_ni, state_q == S_DIV, div_cnt_q < DCW'(FRAC_W), "divider ran past fraction width")
  `KVI_ASSERT_IMP(a_seg_range, clk_i, rst_ni, state_q == S_SEG_RD, (CW'(seg_q) + CW'(1)) < n_q, "segment index beyond key count")
  `KVI_ASSERT_IMP(a_valid_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_EMIT), "result raised outside emit state")
  `KVI_ASSERT_NXT(a_emit_hold, clk_i, rst_ni, state_q == S_EMIT && !out_free, state_q == S_EMIT, "pending result overwritten")

endmodule
